### rtl/tes_pkg.sv
// tes_pkg: shared types, codes and helpers for the timer event scheduler.
// No dependencies; imported by tes_ram users, the top level and its checker.
package tes_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int TIME_W     = 48;
  localparam int PER_W      = 32;
  localparam int TMR_W      = TIME_W + PER_W;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] RES_ADDED   = 3'd0;
  localparam logic [2:0] RES_FULL    = 3'd1;
  localparam logic [2:0] RES_REMOVED = 3'd2;
  localparam logic [2:0] RES_UNKNOWN = 3'd3;
  localparam logic [2:0] RES_FIRED   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REM,
    ST_SCAN,
    ST_PICK
  } tes_state_t;

  // Saturating 48-bit add.
  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

### rtl/tes_ram.sv
// tes_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/timer_event_scheduler_unit.sv
// Timer event scheduler: 16 timers; deadline/period and the free-id stack in RAMs.
// Depends on tes_pkg and tes_ram.
// Add and remove each present a single result, registered from ST_ADD or ST_REM;
// a held result that stalls the output delays it.
// A tick runs k+1 scan passes (k = timers fired): 16 RAM reads, the read pipeline
// and one pick/write-back step; results trail each fire by one pass.
// One item at a time: s_tready is high only while no item is in progress.
// Reset (rst, synchronous) clears time, armed bits, high-water and stack pointer.
module timer_event_scheduler_unit
  import tes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [31:0] delay_ticks, [63:32] period_ticks,
                                 // [67:64] timer_id, [71:68] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] result_id, [7:4] zero
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast    // last
);

  tes_state_t state, state_next;

  // Latched item
  logic [PER_W-1:0]  in_delay;
  logic [PER_W-1:0]  in_per;
  logic [ID_W-1:0]   in_id;

  logic [TIME_W-1:0] now_count;
  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] done;
  logic [CNT_W-1:0]  high_water;
  logic [CNT_W-1:0]  free_top;

  // Scan pipeline
  logic [CNT_W-1:0]  cnt;
  logic              rd_vld;
  logic [ID_W-1:0]   rd_id;
  logic              best_vld;
  logic [ID_W-1:0]   best_id;
  logic [TIME_W-1:0] best_dl;
  logic [PER_W-1:0]  best_per;
  logic              pend_vld;
  logic [ID_W-1:0]   pend_id;

  // RAM ports
  logic              tmr_we;
  logic [ID_W-1:0]   tmr_waddr;
  logic [TMR_W-1:0]  tmr_wdata;
  logic [TMR_W-1:0]  tmr_rdata;
  logic [TIME_W-1:0] rd_dl;
  logic [PER_W-1:0]  rd_per;
  logic              stk_we;
  logic [ID_W-1:0]   stk_waddr;
  logic [ID_W-1:0]   stk_wdata;
  logic [ID_W-1:0]   stk_raddr;
  logic [ID_W-1:0]   stk_rdata;

  // Control strobes
  logic              emit;
  logic [2:0]        emit_kind;
  logic [ID_W-1:0]   emit_id;
  logic              emit_last;
  logic              arm_set;
  logic              arm_clr;
  logic [ID_W-1:0]   arm_idx;
  logic              push;
  logic              pop_do;
  logic              grow_do;
  logic              fire_go;

  logic              out_free;
  logic              accept;
  logic              pop_ok;
  logic              grow_ok;
  logic [ID_W-1:0]   add_id;
  logic              rem_known;
  logic              cand;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pop_ok    = (free_top != '0);
  assign grow_ok   = (high_water != CNT_W'(NUM_TIMERS));
  assign add_id    = pop_ok ? stk_rdata : high_water[ID_W-1:0];
  assign rem_known = ({1'b0, in_id} < high_water);
  assign rd_dl     = tmr_rdata[TIME_W-1:0];
  assign rd_per    = tmr_rdata[TMR_W-1:TIME_W];
  assign cand      = rd_vld && armed[rd_id] && !done[rd_id] && (rd_dl <= now_count);

  // Deadline and period per slot; scan reads by counter
  tes_ram #(.WIDTH(TMR_W), .DEPTH(NUM_TIMERS)) u_tmr_ram (
    .clk   (clk),
    .we    (tmr_we),
    .waddr (tmr_waddr),
    .wdata (tmr_wdata),
    .raddr (cnt[ID_W-1:0]),
    .rdata (tmr_rdata)
  );

  // LIFO of freed ids; top entry is always being read so a pop is ready next cycle
  assign stk_raddr = free_top[ID_W-1:0] - ID_W'(1);

  tes_ram #(.WIDTH(ID_W), .DEPTH(NUM_TIMERS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_kind  = RES_ADDED;
    emit_id    = '0;
    emit_last  = 1'b1;
    arm_set    = 1'b0;
    arm_clr    = 1'b0;
    arm_idx    = '0;
    push       = 1'b0;
    pop_do     = 1'b0;
    grow_do    = 1'b0;
    fire_go    = 1'b0;
    tmr_we     = 1'b0;
    tmr_waddr  = add_id;
    tmr_wdata  = {in_per, sat_add48(now_count, {16'b0, in_delay})};
    stk_we     = 1'b0;
    stk_waddr  = free_top[ID_W-1:0];
    stk_wdata  = in_id;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            KIND_ADD:    state_next = ST_ADD;
            KIND_REMOVE: state_next = ST_REM;
            KIND_TICK:   state_next = ST_SCAN;
            default:     state_next = ST_IDLE;  // unused kind: dropped
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (pop_ok || grow_ok) begin
            pop_do    = pop_ok;
            grow_do   = !pop_ok;
            tmr_we    = 1'b1;
            arm_set   = 1'b1;
            arm_idx   = add_id;
            emit_kind = RES_ADDED;
            emit_id   = add_id;
          end else begin
            emit_kind = RES_FULL;
          end
        end
      end
      ST_REM: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_id    = in_id;
          state_next = ST_IDLE;
          if (rem_known) begin
            emit_kind = RES_REMOVED;
            if (armed[in_id]) begin
              arm_clr = 1'b1;
              arm_idx = in_id;
              if (free_top != CNT_W'(NUM_TIMERS)) begin
                push   = 1'b1;
                stk_we = 1'b1;
              end
            end
          end else begin
            emit_kind = RES_UNKNOWN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt[CNT_W-1] && !rd_vld) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        emit_kind = RES_FIRED;
        emit_id   = pend_id;
        if (best_vld) begin
          // A new winner flushes the held result as not-last
          if (!pend_vld || out_free) begin
            fire_go    = 1'b1;
            emit       = pend_vld;
            emit_last  = 1'b0;
            state_next = ST_SCAN;
            if (best_per != '0) begin
              tmr_we    = 1'b1;
              tmr_waddr = best_id;
              tmr_wdata = {best_per, sat_add48(best_dl, {16'b0, best_per})};
            end else begin
              arm_clr   = 1'b1;
              arm_idx   = best_id;
              stk_wdata = best_id;
              if (free_top != CNT_W'(NUM_TIMERS)) begin
                push   = 1'b1;
                stk_we = 1'b1;
              end
            end
          end
        end else if (!pend_vld) begin
          state_next = ST_IDLE;                 // quiet tick
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_count  <= '0;
      armed      <= '0;
      done       <= '0;
      high_water <= '0;
      free_top   <= '0;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      best_vld   <= 1'b0;
      pend_vld   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        done     <= '0;
        cnt      <= '0;
        best_vld <= 1'b0;
        pend_vld <= 1'b0;
        if (s_tuser == KIND_TICK) begin
          now_count <= sat_add48(now_count, TIME_W'(1));
        end
      end

      rd_vld <= (state == ST_SCAN) && !cnt[CNT_W-1];
      if (state == ST_SCAN && !cnt[CNT_W-1]) begin
        cnt <= cnt + CNT_W'(1);
      end
      // Strict compare keeps the lower id on equal deadlines
      if (cand && (!best_vld || rd_dl < best_dl)) begin
        best_vld <= 1'b1;
      end

      if (arm_set) armed[arm_idx] <= 1'b1;
      if (arm_clr) armed[arm_idx] <= 1'b0;
      if (push)    free_top <= free_top + CNT_W'(1);
      if (pop_do)  free_top <= free_top - CNT_W'(1);
      if (grow_do) high_water <= high_water + CNT_W'(1);

      if (fire_go) begin
        done[best_id] <= 1'b1;
        pend_vld      <= 1'b1;
        cnt           <= '0;
        best_vld      <= 1'b0;
      end
      if (state == ST_PICK && !best_vld && (!pend_vld || out_free)) begin
        pend_vld <= 1'b0;
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_delay <= s_tdata[31:0];
      in_per   <= s_tdata[63:32];
      in_id    <= s_tdata[67:64];
    end
    rd_id <= cnt[ID_W-1:0];
    if (cand && (!best_vld || rd_dl < best_dl)) begin
      best_id  <= rd_id;
      best_dl  <= rd_dl;
      best_per <= rd_per;
    end
    if (fire_go) begin
      pend_id <= best_id;
    end
    if (emit) begin
      m_tuser <= emit_kind;
      m_tdata <= {4'b0, emit_id};
      m_tlast <= emit_last;
    end
  end

endmodule

### rtl/tes_checker.sv
// tes_checker: port-level assertions for the timer event scheduler, bound to the top.
// Depends on tes_pkg.
module tes_checker
  import tes_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // Held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // One item in flight; an unused kind is dropped at once
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != KIND_NONE |=> !s_tready)
    else $error("item accepted while busy");

  // Only fired results may be non-final
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != RES_FIRED |-> m_tlast)
    else $error("single result without last");

  // Refused add reports id zero; codes stay in range
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != RES_FULL || m_tdata == 8'd0) && m_tuser <= RES_FIRED)
    else $error("bad result code or id");

endmodule

bind timer_event_scheduler_unit tes_checker u_tes_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### verif/timer_event_scheduler_unit_test.sv
// Self-checking bench for timer_event_scheduler_unit: adds, removes and ticks are
// driven on the input stream and every result is checked against a built-in timer table.
// Depends on tes_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module timer_event_scheduler_unit_test
  import tes_pkg::*;
();

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] id;
    logic       last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  timer_event_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow timer table.
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] due_q [NUM_TIMERS];
  logic [PER_W-1:0]  per_q [NUM_TIMERS];
  logic              armed_q [NUM_TIMERS];
  int unsigned       high_q;
  logic [ID_W-1:0]   free_q [$];

  sched_result_t expected_results [$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_sink = 1'b0;

  function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic void queue_result(sched_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one item to the shadow table and queue its results.
  function automatic void predict_schedule(logic [1:0] kind, logic [31:0] dly,
                                           logic [31:0] per, logic [3:0] tid);
    int best;
    int n;
    bit done [NUM_TIMERS];
    logic [ID_W-1:0] id;
    sched_result_t r;
    if (kind == KIND_ADD) begin
      if (free_q.size() > 0) begin
        id = free_q.pop_back();
      end else if (high_q < NUM_TIMERS) begin
        id = high_q[ID_W-1:0];
        high_q++;
      end else begin
        r = '{RES_FULL, 4'd0, 1'b1};
        queue_result(r);
        return;
      end
      due_q[id] = add_sat(now_q, {16'd0, dly});
      per_q[id] = per;
      armed_q[id] = 1'b1;
      r = '{RES_ADDED, id, 1'b1};
      queue_result(r);
    end else if (kind == KIND_REMOVE) begin
      if (tid < high_q) begin
        if (armed_q[tid]) begin
          armed_q[tid] = 1'b0;
          free_q.insert(free_q.size(), tid);
        end
        r = '{RES_REMOVED, tid, 1'b1};
      end else begin
        r = '{RES_UNKNOWN, tid, 1'b1};
      end
      queue_result(r);
    end else if (kind == KIND_TICK) begin
      now_q = add_sat(now_q, 48'd1);
      foreach (done[i]) done[i] = 1'b0;
      n = 0;
      while (n < NUM_TIMERS) begin
        best = -1;
        for (int i = 0; i < NUM_TIMERS; i++)
          if (armed_q[i] && !done[i] && due_q[i] <= now_q)
            if (best < 0 || due_q[i] < due_q[best]) best = i;
        if (best < 0) break;
        done[best] = 1'b1;
        if (per_q[best] != 0) begin
          due_q[best] = add_sat(due_q[best], {16'd0, per_q[best]});
        end else begin
          armed_q[best] = 1'b0;
          free_q.insert(free_q.size(), best[ID_W-1:0]);
        end
        r = '{RES_FIRED, best[ID_W-1:0], 1'b0};
        queue_result(r);
        n++;
      end
      // last flag on the final fire of this tick
      if (n > 0) expected_results[$].last = 1'b1;
    end
  endfunction

  // Idle the input for a random number of cycles; valid drops only for a real gap.
  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Offer one item and hold it until accepted.
  task automatic send_item(logic [1:0] kind, logic [31:0] dly, logic [31:0] per,
                           logic [3:0] tid, bit gaps = 1'b1);
    if (gaps && !hold_off) random_gap();
    s_tuser  <= kind;
    s_tdata  <= {4'd0, tid, per, dly};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_schedule(kind, dly, per, tid);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_add_remove_edges();
    send_item(KIND_REMOVE, 0, 0, 4'd0);          // unknown id on empty table
    send_item(KIND_ADD, 32'd0, 32'd0, 4'd0);     // due immediately, one-shot
    send_item(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_item(KIND_REMOVE, 0, 0, 4'd0);          // armed remove frees id
    send_item(KIND_REMOVE, 0, 0, 4'd0);          // idle id below high water
    send_item(KIND_REMOVE, 0, 0, 4'hF);          // unknown
    send_item(KIND_ADD, 32'd1, 32'd1, 4'd0);     // reuses freed id
    send_item(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF); // unused kind, ignored
    send_item(KIND_TICK, 0, 0, 4'd0);
    send_item(KIND_TICK, 0, 0, 4'd0);
    send_item(KIND_REMOVE, 0, 0, 4'd0);
    send_item(KIND_REMOVE, 0, 0, 4'd1);
    wait_drained();
  endtask

  task automatic test_full_and_burst();
    // Fill the table with equal deadlines so one tick fires sixteen timers.
    for (int i = 0; i < 17; i++) send_item(KIND_ADD, 32'd1, 32'd0, 4'(i));
    send_item(KIND_TICK, 0, 0, 4'd0);
    send_item(KIND_TICK, 0, 0, 4'd0);            // quiet tick
    wait_drained();
  endtask

  task automatic test_backpressure();
    // Sink holds off while adds and ticks keep coming.
    hold_off = 1'b1;
    stall_sink = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        stall_sink = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++)
          send_item(KIND_ADD, 32'(i % 3), $urandom_range(0, 2), 4'd0, 1'b0);
        for (int i = 0; i < 4; i++) send_item(KIND_TICK, 0, 0, 4'd0, 1'b0);
      end
    join
    hold_off = 1'b0;
    wait_drained();   // sender pauses until all results are in
  endtask

  task automatic test_random_traffic();
    logic [31:0] d, p;
    for (int i = 0; i < 217; i++) begin
      case ($urandom_range(0, 19))
        0: begin
          d = $urandom(); p = $urandom();
        end
        1: begin
          d = 32'hFFFF_FFFF; p = $urandom_range(0, 1);
        end
        default: begin
          d = $urandom_range(0, 6); p = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2:    send_item(KIND_ADD, d, p, 4'($urandom()));
        3, 4:       send_item(KIND_REMOVE, $urandom(), $urandom(), 4'($urandom()));
        9:          send_item(($urandom_range(0, 7) == 0) ? KIND_NONE : KIND_TICK,
                              $urandom(), $urandom(), 4'($urandom()));
        default:    send_item(KIND_TICK, $urandom(), $urandom(), 4'($urandom()));
      endcase
    end
    wait_drained();
  endtask

  // Receiver readiness, changed at falling edges.
  always @(negedge clk) begin
    if (rst || stall_sink) m_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_tready <= ~m_tready;
    else m_tready <= 1'b1;
  end

  // Result checker.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d id=%0d last=%0b",
                   m_tuser, m_tdata[3:0], m_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind || m_tdata[3:0] !== want.id || m_tlast !== want.last ||
            m_tdata[7:4] !== 4'd0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind=%0d id=%0d last=%0b, got kind=%0d id=%0d last=%0b",
                     want.kind, want.id, want.last, m_tuser, m_tdata[3:0], m_tlast);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timer_event_scheduler_unit verification failed");
      $finish;
    end
  end

  initial begin
    now_q = '0;
    high_q = 0;
    foreach (armed_q[i]) begin
      armed_q[i] = 1'b0;
      due_q[i] = '0;
      per_q[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_add_remove_edges();
    test_full_and_burst();
    test_backpressure();
    test_random_traffic();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("timer_event_scheduler_unit verification clean");
    end else begin
      $display("timer_event_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/tes_pkg.sv
rtl/tes_ram.sv
rtl/timer_event_scheduler_unit.sv
rtl/tes_checker.sv
verif/timer_event_scheduler_unit_test.sv
